>>> rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, suspended while reset is low
`define E8_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// property checked at every rising edge, reset included
`define E8_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

>>> rtl/e8rl_pkg.sv
// ----------------------------------------------------------------------------
// e8rl_pkg
// Types, constants and helper functions of the run-length bar code decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package e8rl_pkg;

  localparam int unsigned MAX_MODULE_WIDTH = 16;
  localparam int unsigned RUNS_PER_DIGIT   = 4;
  localparam int unsigned QUEUE_DEPTH      = 2;
  localparam int unsigned QPTR_W           = 1;
  localparam int unsigned QCNT_W           = 2;

  typedef logic [3:0] nibble_t;
  typedef logic [4:0] width_t;
  typedef logic [6:0] count_t;
  typedef logic [2:0] ratio_t;
  typedef logic [3:0] digit_t;
  typedef logic [3:0] wsum_t;
  typedef logic [6:0] dsum_t;
  typedef logic [1:0] bit_idx_t;

  localparam count_t RUN_COUNT_MAX = 7'd127;
  localparam ratio_t RATIO_MAX     = 3'd7;
  localparam bit_idx_t LAST_BIT    = 2'd3;

  // one queued nibble, width already clamped
  typedef struct packed {
    nibble_t nibble;
    logic    first;
    logic    last;
    width_t  width;
  } item_t;

  // scan side to digit accumulator
  typedef struct packed {
    logic   clear;
    logic   ev_valid;
    count_t ev_count;
    width_t ev_width;
  } acc_ctrl_t;

  // digit accumulator to scan side
  typedef struct packed {
    wsum_t weighted_total;
    dsum_t digit_total;
  } acc_stat_t;

  function automatic width_t clamp_width(input width_t w);
    width_t res;
    res = w;
    if (w == '0) begin
      res = 5'd1;
    end else if (32'(w) > MAX_MODULE_WIDTH) begin
      res = width_t'(MAX_MODULE_WIDTH);
    end
    return res;
  endfunction

  // quotient of count by width, saturated at seven, three restoring steps
  function automatic ratio_t sat_ratio(input count_t c, input width_t w);
    logic [9:0] rem;
    logic [9:0] dv;
    ratio_t     q;
    rem = {3'b000, c};
    q   = '0;
    if (rem >= {2'b00, w, 3'b000}) begin
      q = RATIO_MAX;
    end else begin
      for (int i = 2; i >= 0; i--) begin
        dv = {5'b00000, w} << i;
        if (rem >= dv) begin
          rem  = rem - dv;
          q[i] = 1'b1;
        end
      end
    end
    return q;
  endfunction

  // bar, space, bar ratios to digit; unknown patterns give zero
  function automatic digit_t classify(input ratio_t a, input ratio_t b, input ratio_t c);
    digit_t d;
    unique case ({a, b, c})
      {3'd1, 3'd1, 3'd2}: d = 4'd0;
      {3'd1, 3'd2, 3'd2}: d = 4'd1;
      {3'd2, 3'd2, 3'd1}: d = 4'd2;
      {3'd1, 3'd1, 3'd4}: d = 4'd3;
      {3'd2, 3'd3, 3'd1}: d = 4'd4;
      {3'd1, 3'd3, 3'd2}: d = 4'd5;
      {3'd4, 3'd1, 3'd1}: d = 4'd6;
      {3'd2, 3'd1, 3'd3}: d = 4'd7;
      {3'd3, 3'd1, 3'd2}: d = 4'd8;
      {3'd2, 3'd1, 3'd1}: d = 4'd9;
      default:            d = 4'd0;
    endcase
    return d;
  endfunction

  // weighted sum kept modulo ten
  function automatic wsum_t wsum_next(input wsum_t t, input digit_t d, input logic odd);
    logic [5:0] s;
    s = {2'b00, t} + (odd ? ({1'b0, d, 1'b0} + {2'b00, d}) : {2'b00, d});
    priority if (s >= 6'd30) begin
      s = s - 6'd30;
    end else if (s >= 6'd20) begin
      s = s - 6'd20;
    end else if (s >= 6'd10) begin
      s = s - 6'd10;
    end
    return s[3:0];
  endfunction

endpackage

>>> rtl/e8rl_channels.sv
// ----------------------------------------------------------------------------
// e8rl channels
// Valid/ready channel bundles for the nibble input and the result output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface e8rl_in_if;
  logic               valid;
  logic               ready;
  e8rl_pkg::nibble_t  nibble;
  logic               first_of_code;
  logic               last_of_code;
  e8rl_pkg::width_t   module_width;

  modport source (output valid, output nibble, output first_of_code,
                  output last_of_code, output module_width, input ready);
  modport sink   (input valid, input nibble, input first_of_code,
                  input last_of_code, input module_width, output ready);
endinterface

interface e8rl_out_if;
  logic             valid;
  logic             ready;
  e8rl_pkg::dsum_t  code_value;
  logic             check_passed;

  modport source (output valid, output code_value, output check_passed, input ready);
  modport sink   (input valid, input code_value, input check_passed, output ready);
endinterface

>>> rtl/e8rl_front.sv
// ----------------------------------------------------------------------------
// e8rl_front
// Takes nibble transfers, clamps the module width and queues the items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module e8rl_front (
  input  logic            clk,
  input  logic            rst_n,
  e8rl_in_if.sink         in_ch,
  output e8rl_pkg::item_t q_item,
  output logic            q_valid,
  input  logic            q_pop
);

  e8rl_pkg::item_t                    mem_r [e8rl_pkg::QUEUE_DEPTH];
  logic [e8rl_pkg::QPTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [e8rl_pkg::QPTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [e8rl_pkg::QCNT_W-1:0]        cnt_r, cnt_nxt;
  logic                               push, pop;
  e8rl_pkg::item_t                    new_item;

  assign in_ch.ready = (cnt_r != e8rl_pkg::QCNT_W'(e8rl_pkg::QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != '0);
  assign pop         = q_pop && q_valid;
  assign q_item      = mem_r[rd_ptr_r];

  always_comb begin
    new_item.nibble = in_ch.nibble;
    new_item.first  = in_ch.first_of_code;
    new_item.last   = in_ch.last_of_code;
    new_item.width  = e8rl_pkg::clamp_width(in_ch.module_width);
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

>>> rtl/e8rl_digit_acc.sv
// ----------------------------------------------------------------------------
// e8rl_digit_acc
// Turns closed runs into ratios, classifies digits and keeps the sums.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module e8rl_digit_acc #(
  parameter int unsigned DIGIT_COUNT = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  e8rl_pkg::acc_ctrl_t  ctrl,
  output e8rl_pkg::acc_stat_t  stat
);

  localparam int unsigned RUN_LIMIT = DIGIT_COUNT * e8rl_pkg::RUNS_PER_DIGIT;
  localparam int unsigned RN_W      = $clog2(RUN_LIMIT + 1);

  logic [RN_W-1:0]      run_number_r, run_number_nxt;
  e8rl_pkg::ratio_t     held_r [2];
  e8rl_pkg::ratio_t     held_nxt [2];
  e8rl_pkg::wsum_t      wsum_r, wsum_nxt;
  e8rl_pkg::dsum_t      dsum_r, dsum_nxt;
  e8rl_pkg::ratio_t     ratio;
  e8rl_pkg::digit_t     digit;
  logic [1:0]           pos;
  logic                 in_range;

  assign ratio    = e8rl_pkg::sat_ratio(ctrl.ev_count, ctrl.ev_width);
  assign digit    = e8rl_pkg::classify(held_r[0], held_r[1], ratio);
  assign pos      = run_number_r[1:0];
  assign in_range = (run_number_r < RN_W'(RUN_LIMIT));

  always_comb begin
    run_number_nxt = run_number_r;
    held_nxt[0]    = held_r[0];
    held_nxt[1]    = held_r[1];
    wsum_nxt       = wsum_r;
    dsum_nxt       = dsum_r;
    if (ctrl.clear) begin
      run_number_nxt = '0;
      held_nxt[0]    = '0;
      held_nxt[1]    = '0;
      wsum_nxt       = '0;
      dsum_nxt       = '0;
    end else if (ctrl.ev_valid && in_range) begin
      run_number_nxt = run_number_r + 1'b1;
      unique case (pos)
        2'd0: held_nxt[0] = ratio;
        2'd1: held_nxt[1] = ratio;
        2'd2: begin
          wsum_nxt = e8rl_pkg::wsum_next(wsum_r, digit, run_number_r[2]);
          dsum_nxt = dsum_r + {3'b000, digit};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_number_r <= '0;
      held_r[0]    <= '0;
      held_r[1]    <= '0;
      wsum_r       <= '0;
      dsum_r       <= '0;
    end else begin
      run_number_r <= run_number_nxt;
      held_r[0]    <= held_nxt[0];
      held_r[1]    <= held_nxt[1];
      wsum_r       <= wsum_nxt;
      dsum_r       <= dsum_nxt;
    end
  end

  assign stat.weighted_total = wsum_r;
  assign stat.digit_total    = dsum_r;

endmodule

>>> rtl/e8rl_back.sv
// ----------------------------------------------------------------------------
// e8rl_back
// Bit-serial run scanner with sequencer and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module e8rl_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  e8rl_pkg::item_t      q_item,
  input  logic                 q_valid,
  output logic                 q_pop,
  output e8rl_pkg::acc_ctrl_t  acc_ctrl,
  input  e8rl_pkg::acc_stat_t  acc_stat,
  e8rl_out_if.source           out_ch
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_BITS  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  e8rl_pkg::nibble_t     nib_r, nib_nxt;
  logic                  first_r, first_nxt;
  logic                  last_r, last_nxt;
  e8rl_pkg::width_t      width_r, width_nxt;
  e8rl_pkg::bit_idx_t    bit_idx_r, bit_idx_nxt;
  logic                  level_r, level_nxt;
  e8rl_pkg::count_t      run_count_r, run_count_nxt;
  logic                  gap_r, gap_nxt;
  logic                  ev_valid_r, ev_valid_nxt;
  e8rl_pkg::count_t      ev_count_r, ev_count_nxt;
  e8rl_pkg::width_t      ev_width_r, ev_width_nxt;
  logic                  out_valid_r, out_valid_nxt;
  e8rl_pkg::dsum_t       out_code_r, out_code_nxt;
  logic                  out_pass_r, out_pass_nxt;

  logic                  fresh;
  logic                  base_level;
  e8rl_pkg::count_t      base_count;
  logic                  base_gap;
  logic                  cur_bit;
  logic                  emit_load;
  logic                  pass;

  // first nibble of a code scans from the cleared state
  assign fresh      = (state_r == S_BITS) && first_r && (bit_idx_r == '0);
  assign base_level = fresh ? 1'b0 : level_r;
  assign base_count = fresh ? '0 : run_count_r;
  assign base_gap   = fresh ? 1'b1 : gap_r;
  assign cur_bit    = nib_r[bit_idx_r];

  assign q_pop = q_valid && ((state_r == S_IDLE) ||
                 ((state_r == S_BITS) && (bit_idx_r == e8rl_pkg::LAST_BIT) && !last_r));

  assign emit_load = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);
  assign pass      = (acc_stat.weighted_total == '0);

  always_comb begin
    state_nxt     = state_r;
    nib_nxt       = nib_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    width_nxt     = width_r;
    bit_idx_nxt   = bit_idx_r;
    level_nxt     = level_r;
    run_count_nxt = run_count_r;
    gap_nxt       = gap_r;
    ev_valid_nxt  = 1'b0;
    ev_count_nxt  = ev_count_r;
    ev_width_nxt  = ev_width_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_code_nxt  = out_code_r;
    out_pass_nxt  = out_pass_r;

    unique case (state_r)
      S_IDLE: begin
      end
      S_BITS: begin
        level_nxt     = base_level;
        run_count_nxt = base_count;
        gap_nxt       = base_gap;
        if (base_gap) begin
          if (cur_bit) begin
            gap_nxt       = 1'b0;
            level_nxt     = 1'b1;
            run_count_nxt = 7'd1;
          end
        end else if (cur_bit == base_level) begin
          if (base_count < e8rl_pkg::RUN_COUNT_MAX) begin
            run_count_nxt = base_count + 1'b1;
          end
        end else begin
          ev_valid_nxt  = 1'b1;
          ev_count_nxt  = base_count;
          ev_width_nxt  = width_r;
          level_nxt     = cur_bit;
          run_count_nxt = 7'd1;
        end
        bit_idx_nxt = bit_idx_r + 1'b1;
        if (bit_idx_r == e8rl_pkg::LAST_BIT) begin
          if (last_r) begin
            state_nxt = S_DRAIN;
          end else if (!q_pop) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_DRAIN: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (emit_load) begin
          out_valid_nxt = 1'b1;
          out_pass_nxt  = pass;
          out_code_nxt  = pass ? acc_stat.digit_total : '0;
          level_nxt     = 1'b0;
          run_count_nxt = '0;
          gap_nxt       = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (q_pop) begin
      nib_nxt     = q_item.nibble;
      first_nxt   = q_item.first;
      last_nxt    = q_item.last;
      width_nxt   = q_item.width;
      bit_idx_nxt = '0;
      state_nxt   = S_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bit_idx_r   <= '0;
      level_r     <= 1'b0;
      run_count_r <= '0;
      gap_r       <= 1'b1;
      ev_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      first_r     <= 1'b0;
      last_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bit_idx_r   <= bit_idx_nxt;
      level_r     <= level_nxt;
      run_count_r <= run_count_nxt;
      gap_r       <= gap_nxt;
      ev_valid_r  <= ev_valid_nxt;
      out_valid_r <= out_valid_nxt;
      first_r     <= first_nxt;
      last_r      <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nib_r      <= nib_nxt;
    width_r    <= width_nxt;
    ev_count_r <= ev_count_nxt;
    ev_width_r <= ev_width_nxt;
    out_code_r <= out_code_nxt;
    out_pass_r <= out_pass_nxt;
  end

  assign acc_ctrl.clear    = fresh || emit_load;
  assign acc_ctrl.ev_valid = ev_valid_r;
  assign acc_ctrl.ev_count = ev_count_r;
  assign acc_ctrl.ev_width = ev_width_r;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.code_value   = out_code_r;
  assign out_ch.check_passed = out_pass_r;

endmodule

>>> rtl/ean8_run_length_decoder_unit.sv
// ----------------------------------------------------------------------------
// ean8_run_length_decoder_unit
// Decodes an 8-digit bar code row from a nibble stream and checks its sum.
// ----------------------------------------------------------------------------
// Channels: in_ch carries one nibble per transfer with first/last markers and
// the module width; out_ch carries one result per code (digit sum, zeroed on
// a failed check, and check flag), sent after the transfer with last_of_code.
// Throughput: the scanner takes one bit per cycle while it holds a nibble,
// and back-to-back nibbles of a code follow without a gap. After a last
// nibble the closing run settles, the result loads and the scanner restarts.
// A result reaches out_ch.valid once a last nibble has left the queue, its
// bits are scanned and the drain and emit states have run.
// A two-entry queue sits between the input and the scanner, so nibbles are
// taken while the scanner works or while a result waits.
// Reset: queue emptied, running state cleared, no result pending.
// Receiver stall: the result stays in the output register, the scanner waits
// with the next result, the queue fills and then in_ch.ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ean8_run_length_decoder_unit #(
  parameter int unsigned DIGIT_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  e8rl_in_if.sink     in_ch,
  e8rl_out_if.source  out_ch
);

  e8rl_pkg::item_t      q_item;
  logic                 q_valid;
  logic                 q_pop;
  e8rl_pkg::acc_ctrl_t  acc_ctrl;
  e8rl_pkg::acc_stat_t  acc_stat;

  e8rl_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  e8rl_digit_acc #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_acc (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (acc_ctrl),
    .stat  (acc_stat)
  );

  e8rl_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_item   (q_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .acc_ctrl (acc_ctrl),
    .acc_stat (acc_stat),
    .out_ch   (out_ch)
  );

endmodule

>>> rtl/e8rl_checker.sv
// ----------------------------------------------------------------------------
// e8rl_checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module e8rl_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input e8rl_pkg::dsum_t  out_code_value,
  input logic             out_check_passed
);

  // a stalled result stays offered
  `E8_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)

  // a stalled result keeps its payload
  `E8_ASSERT(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_code_value) && $stable(out_check_passed))

  // reset drops any pending result
  `E8_ASSERT_ALWAYS(a_rst_out, clk, !rst_n |=> !out_valid)

  // the queue is empty and open right after reset
  `E8_ASSERT_ALWAYS(a_rst_ready, clk, !rst_n |=> in_ready)

endmodule

bind ean8_run_length_decoder_unit e8rl_checker u_e8rl_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_code_value   (out_ch.code_value),
  .out_check_passed (out_ch.check_passed)
);
